>>> design/skh_pkg.sv
// Shared types and codes of the sorted key histogram table.
`timescale 1ns / 1ps
`default_nettype none

package skh_pkg;

   // Operation codes carried in the func field
   typedef enum logic [2:0] {
      FUNC_RECORD    = 3'd0,
      FUNC_CREATE    = 3'd1,
      FUNC_COUNT_KEY = 3'd2,
      FUNC_COUNT_IDX = 3'd3,
      FUNC_KEY_IDX   = 3'd4,
      FUNC_CLEAR     = 3'd5
   } func_type;

   // Result status codes
   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_ABSENT = 2'd1,
      STATUS_FULL   = 2'd2
   } status_type;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_INSERT,
      ST_LOOKUP,
      ST_RESP
   } state_type;

   localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

   typedef logic [8:0] total_type;

   // One bucket as held in the table memory
   typedef struct packed {
      logic signed [31:0] key;
      logic [31:0]        count;
   } entry_type;

   // One result item
   typedef struct packed {
      status_type         status;
      logic [31:0]        count;
      logic signed [31:0] key;
      total_type          total;
   } result_type;

endpackage

`default_nettype wire

>>> design/skh_ram.sv
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module skh_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, read every cycle
   always_ff @(posedge clock) begin
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

>>> design/sorted_key_histogram_table.sv
// Top level of the sorted key histogram table.
//
// Holds up to CAPACITY buckets (key, count) in ascending signed key order in one
// table memory with one write and one registered read port. One request is worked
// on at a time; req_tready is high only while the sequencer is idle. Record, create
// and count-by-key walk the table from index 0, one entry per cycle, until the key,
// a larger key or the end of the entries in use is met. An insert then moves every
// entry at and above the slot up by one, one entry per cycle, and then writes the
// new bucket. The walk stops at the slot and the move runs down from the top entry
// to the slot's own entry, which both therefore touch. Count or key by index passes
// through a lookup state unless the index is out of range; clear and unknown codes
// go straight to the result. Every request ends in a state that hands the result to
// the output register; a result that waits in the output register holds the
// sequencer there. Counts saturate at all ones; an insert into a full table changes
// nothing and reports status full. The table needs no clearing after reset: only
// entries below the occupancy are ever used.
`timescale 1ns / 1ps
`default_nettype none

module sorted_key_histogram_table #(
   parameter int CAPACITY = 256
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // Request channel
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,  // func[2:0], sample_key[34:3], position[42:35]
   // Result channel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [79:0]      rsp_tdata   // status[1:0], count_out[33:2], key_out[65:34],
                                        // bucket_total[74:66]
);

   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int OCC_W  = $clog2(CAPACITY + 1);

   // Sequencer and request registers
   skh_pkg::state_type  state_ff, state_in;
   logic [2:0]          func_ff, func_in;
   logic signed [31:0]  key_ff, key_in;
   logic [7:0]          pos_ff, pos_in;
   logic [OCC_W-1:0]    occ_ff, occ_in;
   logic [ADDR_W-1:0]   scan_ff, scan_in;
   logic [ADDR_W-1:0]   at_ff, at_in;
   logic [ADDR_W-1:0]   dst_ff, dst_in;
   skh_pkg::result_type res_ff, res_in;
   logic                rsp_valid_ff, rsp_valid_in;
   skh_pkg::result_type rsp_data_ff, rsp_data_in;

   // Table memory
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_waddr;
   skh_pkg::entry_type  ram_wdata;
   logic [ADDR_W-1:0]   ram_raddr;
   skh_pkg::entry_type  ram_rdata;

   skh_ram #(
      .WIDTH ($bits(skh_pkg::entry_type)),
      .DEPTH (CAPACITY)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // Scan compare: the shared compare unit sees one entry per cycle
   logic             scan_hit;
   logic             scan_done;
   logic [OCC_W-1:0] scan_next;
   logic [OCC_W-1:0] miss_at;
   logic [31:0]      hit_count;
   logic             slot_free;

   always_comb begin
      scan_next = OCC_W'(scan_ff) + OCC_W'(1);
      scan_hit  = 1'b0;
      scan_done = 1'b1;
      miss_at   = OCC_W'(scan_ff);
      if (occ_ff == '0) begin
         miss_at = '0;
      end else if ($signed(ram_rdata.key) == key_ff) begin
         scan_hit = 1'b1;
      end else if ($signed(ram_rdata.key) > key_ff) begin
         miss_at = OCC_W'(scan_ff);
      end else if (scan_next == occ_ff) begin
         miss_at = scan_next;
      end else begin
         scan_done = 1'b0;
      end
      // Saturating increment for record
      if (func_ff == skh_pkg::FUNC_RECORD && ram_rdata.count != skh_pkg::COUNT_MAX) begin
         hit_count = ram_rdata.count + 32'd1;
      end else begin
         hit_count = ram_rdata.count;
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Next state and datapath control
   always_comb begin
      state_in     = state_ff;
      func_in      = func_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      occ_in       = occ_ff;
      scan_in      = scan_ff;
      at_in        = at_ff;
      dst_in       = dst_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = dst_ff;
      ram_wdata    = ram_rdata;
      ram_raddr    = scan_ff + ADDR_W'(1);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         skh_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            ram_raddr  = '0;
            if (req_tvalid) begin
               func_in      = req_tdata[2:0];
               key_in       = $signed(req_tdata[34:3]);
               pos_in       = req_tdata[42:35];
               scan_in      = '0;
               res_in.status = skh_pkg::STATUS_ABSENT;
               res_in.count  = '0;
               res_in.key    = '0;
               res_in.total  = skh_pkg::total_type'(occ_ff);
               state_in      = skh_pkg::ST_RESP;
               case (skh_pkg::func_type'(req_tdata[2:0])) inside
                  skh_pkg::FUNC_RECORD, skh_pkg::FUNC_CREATE, skh_pkg::FUNC_COUNT_KEY: begin
                     state_in = skh_pkg::ST_SCAN;
                  end
                  skh_pkg::FUNC_COUNT_IDX, skh_pkg::FUNC_KEY_IDX: begin
                     ram_raddr = ADDR_W'(req_tdata[42:35]);
                     if (32'(req_tdata[42:35]) < 32'(occ_ff)) begin
                        state_in = skh_pkg::ST_LOOKUP;
                     end
                  end
                  skh_pkg::FUNC_CLEAR: begin
                     occ_in        = '0;
                     res_in.status = skh_pkg::STATUS_OK;
                     res_in.total  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end

         skh_pkg::ST_SCAN: begin
            if (!scan_done) begin
               scan_in = scan_ff + ADDR_W'(1);
            end else if (func_ff == skh_pkg::FUNC_COUNT_KEY) begin
               // Plain lookup by key
               if (scan_hit) begin
                  res_in.status = skh_pkg::STATUS_OK;
                  res_in.count  = ram_rdata.count;
                  res_in.key    = key_ff;
               end
               state_in = skh_pkg::ST_RESP;
            end else if (scan_hit) begin
               // Existing bucket: write back the updated count
               ram_we        = 1'b1;
               ram_waddr     = scan_ff;
               ram_wdata.key   = key_ff;
               ram_wdata.count = hit_count;
               res_in.status = skh_pkg::STATUS_OK;
               res_in.count  = hit_count;
               res_in.key    = key_ff;
               state_in      = skh_pkg::ST_RESP;
            end else if (occ_ff == OCC_W'(CAPACITY)) begin
               res_in.status = skh_pkg::STATUS_FULL;
               state_in      = skh_pkg::ST_RESP;
            end else begin
               at_in = ADDR_W'(miss_at);
               if (miss_at == occ_ff) begin
                  state_in = skh_pkg::ST_INSERT;
               end else begin
                  dst_in    = ADDR_W'(occ_ff);
                  ram_raddr = ADDR_W'(occ_ff - OCC_W'(1));
                  state_in  = skh_pkg::ST_SHIFT;
               end
            end
         end

         skh_pkg::ST_SHIFT: begin
            // Move entry dst-1 up to dst, reading the next one down meanwhile
            ram_we    = 1'b1;
            ram_waddr = dst_ff;
            ram_wdata = ram_rdata;
            ram_raddr = dst_ff - ADDR_W'(2);
            if (dst_ff - ADDR_W'(1) == at_ff) begin
               state_in = skh_pkg::ST_INSERT;
            end else begin
               dst_in = dst_ff - ADDR_W'(1);
            end
         end

         skh_pkg::ST_INSERT: begin
            ram_we          = 1'b1;
            ram_waddr       = at_ff;
            ram_wdata.key   = key_ff;
            ram_wdata.count = (func_ff == skh_pkg::FUNC_RECORD) ? 32'd1 : 32'd0;
            occ_in          = occ_ff + OCC_W'(1);
            res_in.status   = skh_pkg::STATUS_OK;
            res_in.count    = ram_wdata.count;
            res_in.key      = key_ff;
            res_in.total    = skh_pkg::total_type'(occ_ff + OCC_W'(1));
            state_in        = skh_pkg::ST_RESP;
         end

         skh_pkg::ST_LOOKUP: begin
            res_in.status = skh_pkg::STATUS_OK;
            res_in.count  = ram_rdata.count;
            res_in.key    = ram_rdata.key;
            state_in      = skh_pkg::ST_RESP;
         end

         skh_pkg::ST_RESP: begin
            // Hand the result to the output register once it is free
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = skh_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = skh_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skh_pkg::ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      key_ff      <= key_in;
      pos_ff      <= pos_in;
      scan_ff     <= scan_in;
      at_ff       <= at_in;
      dst_ff      <= dst_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_data_ff.total, rsp_data_ff.key, rsp_data_ff.count,
                        rsp_data_ff.status};

   // Checks
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(CAPACITY))
      else $error("occupancy above capacity");

   a_occ_step: assert property (@(posedge clock) disable iff (reset)
      occ_ff != $past(occ_ff) |-> occ_ff == $past(occ_ff) + OCC_W'(1) || occ_ff == '0)
      else $error("occupancy moved by more than one");

   a_idle_no_write: assert property (@(posedge clock) disable iff (reset)
      state_ff == skh_pkg::ST_IDLE |-> !ram_we)
      else $error("table written while idle");

   a_shift_above_slot: assert property (@(posedge clock) disable iff (reset)
      state_ff == skh_pkg::ST_SHIFT |-> dst_ff > at_ff && OCC_W'(dst_ff) <= occ_ff)
      else $error("shift outside the moved range");

   a_full_no_insert: assert property (@(posedge clock) disable iff (reset)
      state_ff == skh_pkg::ST_INSERT |-> occ_ff < OCC_W'(CAPACITY))
      else $error("insert into a full table");

endmodule

`default_nettype wire

>>> dv/tb_top.sv
// Self-checking testbench of the sorted key histogram table: stream driver, monitor, predictor.
`timescale 1ns / 1ps

module tb_top;
   import skh_pkg::*;

   localparam int TABLE_SIZE = 256;
   localparam int MAX_REPORTS = 10;
   localparam int DRAIN_CYCLES = 2 * TABLE_SIZE + 100;
   localparam int PRESSURE_AFTER = 500;
   localparam int PRESSURE_CYCLES = 400;

   // Codes that the block must reject without touching the table
   localparam logic [2:0] FUNC_SPARE_LO = 3'd6;
   localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

   typedef struct {
      logic [2:0]         func;
      logic signed [31:0] key;
      logic [7:0]         position;
   } table_request;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;   // func[2:0], sample_key[34:3], position[42:35]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // status[1:0], count_out[33:2], key_out[65:34],
                                  // bucket_total[74:66]

   sorted_key_histogram_table #(
      .CAPACITY (TABLE_SIZE)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Stimulus waiting to be offered, and results waiting to arrive
   table_request pending_requests[$];
   result_type   awaited_results[$];

   // Predictor copy of the table
   logic signed [31:0] shadow_key[TABLE_SIZE];
   logic [31:0]        shadow_count[TABLE_SIZE];
   int                 shadow_fill = 0;

   // Generator view of the keys present, used to steer stimulus
   bit gen_keys[int];
   int known_keys[$];

   int           planned_count = 0;
   int           accepted_count = 0;
   int           results_seen = 0;
   int           fail_count = 0;
   table_request offered;
   int           gap_left = 0;
   int           stall_left = 0;
   int           hold_left = 0;
   bit           pressure_done = 1'b0;

   initial begin
      forever #5 clock = ~clock;
   end

   // Works out the result of one operation and updates the copy of the table
   function automatic result_type apply_table_op(input table_request item);
      result_type r;
      int         slot;
      int         i;
      r.status = STATUS_ABSENT;
      r.count = '0;
      r.key = '0;
      case (item.func)
         FUNC_RECORD, FUNC_CREATE: begin
            slot = 0;
            while (slot < shadow_fill && shadow_key[slot] < item.key) slot++;
            if (slot < shadow_fill && shadow_key[slot] == item.key) begin
               if (item.func == FUNC_RECORD && shadow_count[slot] != COUNT_MAX)
                  shadow_count[slot]++;
               r.status = STATUS_OK;
               r.count = shadow_count[slot];
               r.key = item.key;
            end else if (shadow_fill < TABLE_SIZE) begin
               for (i = shadow_fill; i > slot; i--) begin
                  shadow_key[i] = shadow_key[i - 1];
                  shadow_count[i] = shadow_count[i - 1];
               end
               shadow_key[slot] = item.key;
               shadow_count[slot] = (item.func == FUNC_RECORD) ? 32'd1 : 32'd0;
               shadow_fill++;
               r.status = STATUS_OK;
               r.count = shadow_count[slot];
               r.key = item.key;
            end else begin
               r.status = STATUS_FULL;
            end
         end
         FUNC_COUNT_KEY: begin
            for (i = 0; i < shadow_fill; i++) begin
               if (shadow_key[i] == item.key) begin
                  r.status = STATUS_OK;
                  r.count = shadow_count[i];
                  r.key = item.key;
               end
            end
         end
         FUNC_COUNT_IDX, FUNC_KEY_IDX: begin
            if (item.position < shadow_fill) begin
               r.status = STATUS_OK;
               r.count = shadow_count[item.position];
               r.key = shadow_key[item.position];
            end
         end
         FUNC_CLEAR: begin
            shadow_fill = 0;
            r.status = STATUS_OK;
         end
         default: ;
      endcase
      r.total = total_type'(shadow_fill);
      return r;
   endfunction

   // Mostly short gaps, a few long ones, none in a calm stretch
   function automatic int draw_gap(input bit calm);
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Key for a request: mostly one already present, some extremes, some fresh
   function automatic logic signed [31:0] choose_key();
      int r;
      r = $urandom_range(0, 9);
      if (r < 6 && known_keys.size() != 0)
         return known_keys[$urandom_range(0, known_keys.size() - 1)];
      if (r == 9) begin
         case ($urandom_range(0, 4))
            0: return 32'sh8000_0000;
            1: return 32'sh7FFF_FFFF;
            2: return 32'sh0000_0000;
            3: return -32'sd1;
            default: return 32'sd1;
         endcase
      end
      return $urandom;
   endfunction

   task automatic queue_request(input logic [2:0] code, input logic signed [31:0] key,
                                input logic [7:0] where);
      table_request item;
      item.func = code;
      item.key = key;
      item.position = where;
      pending_requests.push_back(item);
      planned_count++;
      if ((code == FUNC_RECORD || code == FUNC_CREATE) && !gen_keys.exists(int'(key))
          && known_keys.size() < TABLE_SIZE) begin
         gen_keys[int'(key)] = 1'b1;
         known_keys.push_back(int'(key));
      end else if (code == FUNC_CLEAR) begin
         gen_keys.delete();
         known_keys.delete();
      end
   endtask

   task automatic queue_random_request();
      int         r;
      int         top;
      logic [2:0] code;
      logic [7:0] where;
      r = $urandom_range(0, 99);
      if (r < 40) code = FUNC_RECORD;
      else if (r < 50) code = FUNC_CREATE;
      else if (r < 66) code = FUNC_COUNT_KEY;
      else if (r < 80) code = FUNC_COUNT_IDX;
      else if (r < 95) code = FUNC_KEY_IDX;
      else if (r == 95) code = FUNC_SPARE_LO;
      else if (r == 96) code = FUNC_SPARE_HI;
      else if (r == 97) code = FUNC_CLEAR;
      else code = FUNC_RECORD;
      // Index mostly within the occupancy or just past it
      top = (known_keys.size() > 255) ? 255 : known_keys.size();
      if ($urandom_range(0, 3) != 0) where = 8'($urandom_range(0, top));
      else where = 8'($urandom_range(0, 255));
      queue_request(code, choose_key(), where);
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(apply_table_op(offered));
            accepted_count++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0 || pending_requests.size() == 0) begin
               if (gap_left > 0) gap_left--;
               req_tvalid <= 1'b0;
            end else begin
               offered = pending_requests.pop_front();
               req_tdata <= {5'b0, offered.position, offered.key, offered.func};
               req_tvalid <= 1'b1;
               gap_left = draw_gap((accepted_count / 150) % 4 == 2);
            end
         end
      end
   end

   task automatic report_mismatch(input string what, input result_type want,
                                  input result_type got);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("%0t %s: got status %0d count %h key %h total %0d, expected status %0d count %h key %h total %0d",
                  $realtime, what, got.status, got.count, got.key, got.total,
                  want.status, want.count, want.key, want.total);
   endtask

   // Result monitor and receiver back-pressure
   always @(posedge clock) begin
      result_type got;
      result_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            got.status = status_type'(rsp_tdata[1:0]);
            got.count = rsp_tdata[33:2];
            got.key = rsp_tdata[65:34];
            got.total = rsp_tdata[74:66];
            if (awaited_results.size() == 0) begin
               want = '0;
               report_mismatch("result with no request outstanding", want, got);
            end else begin
               want = awaited_results.pop_front();
               if (got.status !== want.status || got.count !== want.count
                   || got.key !== want.key || got.total !== want.total)
                  report_mismatch("result mismatch", want, got);
            end
         end
         // One long hold-off so that the block backs up onto its input
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (!pressure_done && results_seen >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            hold_left = PRESSURE_CYCLES;
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            if ((results_seen / 170) % 4 != 1 && $urandom_range(0, 3) == 0)
               stall_left = draw_gap(1'b0);
            rsp_tready <= (stall_left == 0);
         end
      end
   end

   // Stimulus and end of run
   initial begin
      // Empty table lookups
      queue_request(FUNC_COUNT_KEY, 32'sd0, 8'd0);
      queue_request(FUNC_COUNT_IDX, 32'sd0, 8'd0);
      queue_request(FUNC_KEY_IDX, -32'sd1, 8'd255);
      // Inserts at the top, the bottom and in between
      queue_request(FUNC_RECORD, 32'sh7FFF_FFFF, 8'd0);
      queue_request(FUNC_RECORD, 32'sh8000_0000, 8'd255);
      queue_request(FUNC_RECORD, 32'sd0, 8'd0);
      queue_request(FUNC_RECORD, 32'sh7FFF_FFFF, 8'd0);
      // Create on a present key reports the existing bucket
      queue_request(FUNC_CREATE, 32'sh8000_0000, 8'd0);
      queue_request(FUNC_CREATE, 32'sd1, 8'd0);
      queue_request(FUNC_RECORD, -32'sd1, 8'd0);
      queue_request(FUNC_COUNT_KEY, 32'sd1, 8'd0);
      queue_request(FUNC_COUNT_KEY, 32'sh7FFF_FFFF, 8'd0);
      queue_request(FUNC_COUNT_KEY, 32'sd2, 8'd0);
      // Index reads, the last one in use and just past it
      queue_request(FUNC_COUNT_IDX, 32'sd0, 8'd0);
      queue_request(FUNC_KEY_IDX, 32'sd0, 8'd0);
      queue_request(FUNC_KEY_IDX, 32'sd0, 8'd4);
      queue_request(FUNC_COUNT_IDX, 32'sd0, 8'd5);
      queue_request(FUNC_KEY_IDX, 32'sd0, 8'd255);
      queue_request(FUNC_SPARE_LO, $urandom, 8'($urandom));
      queue_request(FUNC_SPARE_HI, $urandom, 8'($urandom));
      // Clear, then the old entries must be gone
      queue_request(FUNC_CLEAR, 32'sd0, 8'd0);
      queue_request(FUNC_COUNT_IDX, 32'sd0, 8'd0);
      queue_request(FUNC_COUNT_KEY, 32'sd0, 8'd0);
      queue_request(FUNC_RECORD, 32'sd0, 8'd0);
      queue_request(FUNC_KEY_IDX, 32'sd0, 8'd0);

      repeat (550) queue_random_request();

      // Fill the table to capacity, then work on it while full
      queue_request(FUNC_CLEAR, $urandom, 8'($urandom));
      while (known_keys.size() < TABLE_SIZE)
         queue_request(($urandom_range(0, 3) == 0) ? FUNC_CREATE : FUNC_RECORD,
                       $urandom, 8'($urandom));
      queue_request(FUNC_RECORD, $urandom, 8'd0);
      queue_request(FUNC_CREATE, $urandom, 8'd0);
      queue_request(FUNC_COUNT_IDX, 32'sd0, 8'd255);
      queue_request(FUNC_KEY_IDX, 32'sd0, 8'd255);
      repeat (30) queue_random_request();
      queue_request(FUNC_CLEAR, $urandom, 8'($urandom));

      repeat (550) queue_random_request();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < planned_count || awaited_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("sorted_key_histogram_table regression: pass");
      end else begin
         $display("sorted_key_histogram_table regression: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #40_000_000;
      $display("sorted_key_histogram_table regression: fail");
      $finish;
   end

endmodule
